>>> rtl/pdp_pkg.sv
// ----------------------------------------------------------------------------
// pdp_pkg
// Types, codes and constants shared by the dongle port model files.
// ----------------------------------------------------------------------------
package pdp_pkg;

  localparam int unsigned DEF_TIMEOUT_CYCLES = 102400;

  localparam int KIND_W = 4;
  localparam int OP_W   = 3;

  // dongle kinds
  localparam logic [KIND_W-1:0] KIND_NONE        = 4'd0;
  localparam logic [KIND_W-1:0] KIND_JOY_ADD     = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LEADER      = 4'd2;
  localparam logic [KIND_W-1:0] KIND_SERIAL      = 4'd3;
  localparam logic [KIND_W-1:0] KIND_ITALIA      = 4'd4;
  localparam logic [KIND_W-1:0] KIND_DRAUGHTS    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_RUGBY       = 4'd6;
  localparam logic [KIND_W-1:0] KIND_CRICKET     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_TANK        = 4'd8;
  localparam logic [KIND_W-1:0] KIND_MUSIC       = 4'd9;
  localparam logic [KIND_W-1:0] KIND_SPREADSHEET = 4'd10;

  // access operations
  localparam logic [OP_W-1:0] OP_CIA_READ  = 3'd0;
  localparam logic [OP_W-1:0] OP_CIA_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_JOY_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_POT_START = 3'd3;
  localparam logic [OP_W-1:0] OP_POTGO     = 3'd4;
  localparam logic [OP_W-1:0] OP_ANALOG    = 3'd5;

  // configuration register index
  localparam logic REG_DONGLE_KIND = 1'b0;

  localparam logic [7:0]  CTS_BIT      = 8'h10;
  localparam logic [7:0]  DTR_BIT      = 8'h80;
  localparam logic [15:0] JOY_MASK     = 16'h0303;
  localparam logic [15:0] JOY_SET_A    = 16'h0101;
  localparam logic [15:0] JOY_SET_B    = 16'h0301;
  localparam logic [15:0] JOY_STEP     = 16'h0100;
  localparam logic [15:0] POTGO_BIT    = 16'h4000;
  localparam logic [6:0]  POT_ITALIA_X = 7'd73;
  localparam logic [6:0]  POT_SHEET_X  = 7'd21;
  localparam logic [6:0]  POT_SHEET_Y  = 7'd10;
  localparam logic [6:0]  POT_DRAFT_X  = 7'd43;
  localparam logic [6:0]  POT_DRAFT_Y  = 7'd80;
  localparam logic [3:0]  JITTER_BIAS  = 4'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic        cia_select;
    logic [3:0]  reg_index;
    logic        port_number;
    logic        axis_select;
    logic [15:0] data_value;
    logic [7:0]  direction_bits;
    logic [31:0] now_cycles;
    logic [2:0]  jitter_bits;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic        pot_valid;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  mode_flag;
    logic [31:0] pulse_time;
  } pdp_state_t;

endpackage

>>> rtl/protection_dongle_port_model.sv
// ----------------------------------------------------------------------------
// protection_dongle_port_model
// Port-access model of ten copy-protection dongle kinds.
// ----------------------------------------------------------------------------
// Each item is one port access; the altered value or pot count comes out of a
// result register, and a new item can be taken every cycle while the skid
// register is empty. Flag and timestamp update in the accepting cycle, so
// back-to-back items see the state left by the previous one. A two-deep output
// (result register plus skid register) keeps the input open for one more item
// while a result is held by out_stall; in_stall is the skid register's valid
// bit. The dongle kind lives at byte address 0 of the APB port and should only
// be changed with no items in flight.
module protection_dongle_port_model #(
  parameter int unsigned TIMEOUT_CYCLES = pdp_pkg::DEF_TIMEOUT_CYCLES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pdp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output pdp_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pdp_pkg::*;

  logic [KIND_W-1:0] kind_r;
  pdp_state_t        state_r;
  pdp_state_t        state_calc;
  out_item_t         res_calc;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r,  out_item_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t skid_item_r,  skid_item_nxt;

  logic in_acc;
  logic out_take;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DONGLE_KIND) ? {28'h0, kind_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_NONE;
    end else if (cfg_wr && paddr[2] == REG_DONGLE_KIND) begin
      kind_r <= pwdata[KIND_W-1:0];
    end
  end

  pdp_access #(
    .TIMEOUT_CYCLES(TIMEOUT_CYCLES)
  ) u_access (
    .kind      (kind_r),
    .item      (in_item),
    .state_cur (state_r),
    .state_nxt (state_calc),
    .result    (res_calc)
  );

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    skid_valid_nxt = skid_valid_r;
    skid_item_nxt  = skid_item_r;
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_acc;
        out_item_nxt  = res_calc;
      end
    end else if (in_acc) begin
      // result register is held, park the new result
      skid_valid_nxt = 1'b1;
      skid_item_nxt  = res_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      state_r      <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (in_acc) state_r <= state_calc;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while the result register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_take) |=> (out_valid_r && !skid_valid_r))
    else $error("skid item not moved to the result register");

  a_pot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.pot_valid) |-> (out_item_r.result_value[15:7] == 9'd0))
    else $error("pot count out of range");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && out_valid_r && !out_take) |=> skid_valid_r)
    else $error("accepted item dropped while output held");

endmodule

>>> rtl/pdp_access.sv
// ----------------------------------------------------------------------------
// pdp_access
// Per-access dongle logic: result and next flag/timestamp for one item.
// ----------------------------------------------------------------------------
module pdp_access #(
  parameter int unsigned TIMEOUT_CYCLES = pdp_pkg::DEF_TIMEOUT_CYCLES
) (
  input  logic [pdp_pkg::KIND_W-1:0] kind,
  input  pdp_pkg::in_item_t          item,
  input  pdp_pkg::pdp_state_t        state_cur,
  output pdp_pkg::pdp_state_t        state_nxt,
  output pdp_pkg::out_item_t         result
);
  import pdp_pkg::*;

  logic [3:0]  flag;
  logic [3:0]  flag_tgl;
  logic [7:0]  cia_val;
  logic [31:0] elapsed;
  logic [15:0] joy_val;
  logic        pot_hit;
  logic [6:0]  pot_base;
  logic [7:0]  pot_sum;

  assign flag     = state_cur.mode_flag;
  assign flag_tgl = {flag[3:1], ~flag[0]};
  assign cia_val  = item.data_value[7:0];
  assign elapsed  = item.now_cycles - state_cur.pulse_time;
  assign joy_val  = item.data_value;

  // pot base counts, only joystick 1 answers
  always_comb begin
    pot_hit  = 1'b0;
    pot_base = '0;
    if (item.port_number) begin
      case (kind)
        KIND_ITALIA: begin
          pot_hit  = !item.axis_select;
          pot_base = POT_ITALIA_X;
        end
        KIND_SPREADSHEET: begin
          pot_hit  = 1'b1;
          pot_base = item.axis_select ? POT_SHEET_Y : POT_SHEET_X;
        end
        KIND_DRAUGHTS: begin
          pot_hit  = 1'b1;
          pot_base = item.axis_select ? POT_DRAFT_Y : POT_DRAFT_X;
        end
        default: ;
      endcase
    end
  end

  assign pot_sum = {1'b0, pot_base} + {{4{flag[3]}}, flag};

  always_comb begin
    state_nxt           = state_cur;
    result.result_value = '0;
    result.pot_valid    = 1'b0;
    unique case (item.operation)
      OP_CIA_READ: begin
        result.result_value = {8'h00, cia_val};
        if (kind == KIND_SERIAL && item.cia_select && item.reg_index == 4'd0) begin
          if (flag == 4'd0 || elapsed > 32'(TIMEOUT_CYCLES)) begin
            result.result_value = {8'h00, cia_val & ~CTS_BIT};
            state_nxt.mode_flag = 4'd0;
          end else begin
            result.result_value = {8'h00, cia_val | CTS_BIT};
          end
        end
      end
      OP_CIA_WRITE: begin
        if (item.reg_index == 4'd0) begin
          case (kind)
            KIND_JOY_ADD: begin
              if (!item.cia_select && cia_val[7]) state_nxt.mode_flag = flag_tgl;
            end
            KIND_SERIAL: begin
              if (item.cia_select && (cia_val & DTR_BIT) == 8'h00) begin
                state_nxt.mode_flag  = 4'd1;
                state_nxt.pulse_time = item.now_cycles;
              end
            end
            KIND_MUSIC: begin
              if (!item.cia_select) begin
                state_nxt.mode_flag = (!cia_val[7] && item.direction_bits[7]) ? 4'd1 : 4'd0;
              end
            end
            default: ;
          endcase
        end
      end
      OP_JOY_READ: begin
        result.result_value = joy_val;
        case (kind)
          KIND_JOY_ADD: begin
            if (item.port_number && flag != 4'd0) result.result_value = joy_val + JOY_STEP;
          end
          KIND_LEADER: begin
            if (item.port_number) result.result_value = (joy_val & ~JOY_MASK) | JOY_SET_A;
          end
          KIND_TANK: begin
            if (!item.port_number) result.result_value = (joy_val & ~JOY_MASK) | JOY_SET_A;
          end
          KIND_RUGBY: begin
            if (item.port_number) result.result_value = (joy_val & ~JOY_MASK) | JOY_SET_B;
          end
          KIND_CRICKET: begin
            if (!item.port_number) begin
              result.result_value = {joy_val[15:2], (flag == 4'd0) ? 2'b01 : 2'b10};
            end
            // flag toggles on either port
            state_nxt.mode_flag = flag_tgl;
          end
          KIND_MUSIC: begin
            if (item.port_number) begin
              if (flag == 4'd0) begin
                result.result_value = '0;
              end else if (flag == 4'd1) begin
                result.result_value = '0;
                state_nxt.mode_flag = 4'd2;
              end else if (flag == 4'd2) begin
                result.result_value = JOY_MASK;
              end
            end
          end
          default: ;
        endcase
      end
      OP_POT_START: begin
        if (kind == KIND_ITALIA || kind == KIND_SPREADSHEET || kind == KIND_DRAUGHTS) begin
          state_nxt.mode_flag = {1'b0, item.jitter_bits} - JITTER_BIAS;
        end
      end
      OP_POTGO: begin
        result.result_value = item.data_value;
        if (kind == KIND_SPREADSHEET) result.result_value = item.data_value | POTGO_BIT;
      end
      OP_ANALOG: begin
        if (pot_hit) begin
          result.pot_valid    = 1'b1;
          // negative counts saturate at zero
          result.result_value = pot_sum[7] ? 16'h0000 : {8'h00, pot_sum};
        end
      end
      default: ;
    endcase
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the protection dongle port model: a queue-fed
// driver offers port accesses under several dongle kinds and idling patterns,
// a predictor tracks the flag and pulse timestamp, and a monitor compares
// every result with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pdp_pkg::*;

  localparam int unsigned SERIAL_TIMEOUT = DEF_TIMEOUT_CYCLES;
  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          BLOCK_ITEMS    = 50;
  localparam int          RANDOM_BLOCKS  = 24;
  localparam int          HOLD_CYCLES    = 60;

  // operation codes with no function in the block
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam logic [2:0] KIND_ADDR = {REG_DONGLE_KIND, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the block's configuration and state
  logic [KIND_W-1:0] kind_setting = KIND_NONE;
  logic signed [3:0] dongle_flag = '0;
  logic [31:0]       pulse_stamp = '0;

  in_item_t  access_queue[$];
  out_item_t expected_results[$];
  int        items_left = 0;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      start_hold = 1'b0;
  logic      hold_off = 1'b0;
  logic [31:0] time_base = '0;

  protection_dongle_port_model #(
    .TIMEOUT_CYCLES(SERIAL_TIMEOUT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch in %0s: expected %h, got %h (cycle %0d)", what, want, got,
             cycle_count);
    mismatches++;
  endtask

  // dongle effect on one port access; updates flag and timestamp
  function automatic out_item_t predict_access(in_item_t a);
    out_item_t   r;
    logic [7:0]  b;
    logic [15:0] v;
    logic [31:0] elapsed;
    int          pot;
    r = '0;
    v = a.data_value;
    case (a.operation)
      OP_CIA_READ: begin
        b = a.data_value[7:0];
        if (kind_setting == KIND_SERIAL && a.cia_select && a.reg_index == 4'd0) begin
          elapsed = a.now_cycles - pulse_stamp;
          if (dongle_flag == 4'sd0 || elapsed > SERIAL_TIMEOUT) begin
            b = b & ~CTS_BIT;
            dongle_flag = 4'sd0;
          end else begin
            b = b | CTS_BIT;
          end
        end
        r.result_value = {8'h00, b};
      end
      OP_CIA_WRITE: begin
        b = a.data_value[7:0];
        if (a.reg_index == 4'd0) begin
          case (kind_setting)
            KIND_JOY_ADD: begin
              if (!a.cia_select && (b & DTR_BIT) != 0) dongle_flag[0] = ~dongle_flag[0];
            end
            KIND_SERIAL: begin
              if (a.cia_select && (b & DTR_BIT) == 0) begin
                dongle_flag = 4'sd1;
                pulse_stamp = a.now_cycles;
              end
            end
            KIND_MUSIC: begin
              if (!a.cia_select)
                dongle_flag = ((b & DTR_BIT) == 0 && (a.direction_bits & DTR_BIT) != 0)
                              ? 4'sd1 : 4'sd0;
            end
            default: ;
          endcase
        end
      end
      OP_JOY_READ: begin
        case (kind_setting)
          KIND_JOY_ADD: if (a.port_number && dongle_flag != 4'sd0) v = v + JOY_STEP;
          KIND_LEADER:  if (a.port_number) v = (v & ~JOY_MASK) | JOY_SET_A;
          KIND_TANK:    if (!a.port_number) v = (v & ~JOY_MASK) | JOY_SET_A;
          KIND_RUGBY:   if (a.port_number) v = (v & ~JOY_MASK) | JOY_SET_B;
          KIND_CRICKET: begin
            if (!a.port_number) v = {v[15:2], (dongle_flag == 4'sd0) ? 2'b01 : 2'b10};
            dongle_flag[0] = ~dongle_flag[0];
          end
          KIND_MUSIC: begin
            if (a.port_number) begin
              if (dongle_flag == 4'sd0) begin
                v = '0;
              end else if (dongle_flag == 4'sd1) begin
                v = '0;
                dongle_flag = 4'sd2;
              end else if (dongle_flag == 4'sd2) begin
                v = JOY_MASK;
              end
            end
          end
          default: ;
        endcase
        r.result_value = v;
      end
      OP_POT_START: begin
        if (kind_setting == KIND_ITALIA || kind_setting == KIND_SPREADSHEET ||
            kind_setting == KIND_DRAUGHTS)
          dongle_flag = $signed({1'b0, a.jitter_bits}) - $signed(JITTER_BIAS);
      end
      OP_POTGO: begin
        r.result_value = (kind_setting == KIND_SPREADSHEET) ? (v | POTGO_BIT) : v;
      end
      OP_ANALOG: begin
        pot = -1;
        if (a.port_number) begin
          case (kind_setting)
            KIND_ITALIA:      if (!a.axis_select) pot = int'(POT_ITALIA_X);
            KIND_SPREADSHEET: pot = a.axis_select ? int'(POT_SHEET_Y) : int'(POT_SHEET_X);
            KIND_DRAUGHTS:    pot = a.axis_select ? int'(POT_DRAFT_Y) : int'(POT_DRAFT_X);
            default: ;
          endcase
        end
        if (pot >= 0) begin
          pot = pot + int'(dongle_flag);
          if (pot < 0) pot = 0;
          r.result_value = pot[15:0];
          r.pot_valid    = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver: one item offered at a time, held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_access(in_item));
        items_left--;
      end
      if (!in_valid || !in_stall) begin
        if (access_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= access_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, {15'b0, out_item});
      end else begin
        want = expected_results.pop_front();
        if (out_item.result_value !== want.result_value)
          report_mismatch("result_value", {16'b0, want.result_value},
                          {16'b0, out_item.result_value});
        if (out_item.pot_valid !== want.pot_valid)
          report_mismatch("pot_valid", {31'b0, want.pot_valid}, {31'b0, out_item.pot_valid});
      end
    end
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (start_hold);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_item(in_item_t a);
    access_queue.push_back(a);
    items_left++;
  endtask

  task automatic queue_access(logic [2:0] op, logic cia, logic [3:0] rgi, logic port,
                              logic axis, logic [15:0] val, logic [7:0] dir,
                              logic [31:0] now, logic [2:0] jit);
    in_item_t a;
    a.operation      = op;
    a.cia_select     = cia;
    a.reg_index      = rgi;
    a.port_number    = port;
    a.axis_select    = axis;
    a.data_value     = val;
    a.direction_bits = dir;
    a.now_cycles     = now;
    a.jitter_bits    = jit;
    queue_item(a);
  endtask

  // mostly targeted at the register the current kind reacts to
  function automatic in_item_t random_access();
    in_item_t a;
    if ($urandom_range(99) < 5)
      a.operation = $urandom_range(1) ? OP_SPARE_B : OP_SPARE_A;
    else
      a.operation = 3'($urandom_range(5));
    if ($urandom_range(3) != 0) begin
      a.cia_select = (kind_setting == KIND_SERIAL);
      a.reg_index  = 4'd0;
    end else begin
      a.cia_select = 1'($urandom_range(1));
      a.reg_index  = 4'($urandom_range(15));
    end
    a.port_number    = 1'($urandom_range(1));
    a.axis_select    = 1'($urandom_range(1));
    a.data_value     = 16'($urandom);
    a.direction_bits = 8'($urandom);
    if ($urandom_range(99) < 85) begin
      time_base    = time_base + 32'($urandom_range(40000));
      a.now_cycles = time_base;
    end else begin
      a.now_cycles = $urandom;
    end
    a.jitter_bits = 3'($urandom_range(7));
    return a;
  endfunction

  task automatic wait_drained();
    while (items_left != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_kind(logic [KIND_W-1:0] k);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= KIND_ADDR;
    pwdata  <= {{(32-KIND_W){1'b0}}, k};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    kind_setting = k;
    // read back
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(32-KIND_W){1'b0}}, k})
      report_mismatch("dongle kind readback", {{(32-KIND_W){1'b0}}, k}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endtask

  initial begin : stimulus
    int blk;
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(0);

    // serial dongle: no pulse yet, pulse, edge of timeout, wrapped time
    write_kind(KIND_SERIAL);
    queue_access(OP_CIA_READ,  1, 0, 0, 0, 16'h00FF, 8'h00, 32'd0, 0);
    queue_access(OP_CIA_WRITE, 1, 0, 0, 0, 16'h0000, 8'hFF, 32'd1000, 0);
    queue_access(OP_CIA_READ,  1, 0, 0, 0, 16'hFF00, 8'h00, 32'd1000 + SERIAL_TIMEOUT, 0);
    queue_access(OP_CIA_READ,  1, 0, 0, 0, 16'hFF10, 8'h00,
                 32'd1001 + SERIAL_TIMEOUT, 0);
    queue_access(OP_CIA_WRITE, 1, 0, 0, 0, 16'h007F, 8'h00, 32'hFFFF_FF00, 0);
    queue_access(OP_CIA_READ,  1, 0, 1, 1, 16'hFFFF, 8'hFF, 32'h0000_0100, 7);
    queue_access(OP_CIA_WRITE, 1, 0, 0, 0, 16'h0080, 8'h00, 32'd0, 0);
    queue_access(OP_SPARE_A,   1, 15, 1, 1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 7);
    queue_access(OP_SPARE_B,   0, 0, 0, 0, 16'h0000, 8'h00, 32'd0, 0);
    wait_drained();

    // joystick sum wraps past 16 bits
    write_kind(KIND_JOY_ADD);
    queue_access(OP_JOY_READ,  0, 0, 1, 0, 16'hFFFF, 8'h00, 32'd0, 0);
    queue_access(OP_CIA_WRITE, 0, 0, 0, 0, 16'h0080, 8'h00, 32'd0, 0);
    queue_access(OP_JOY_READ,  0, 0, 1, 0, 16'hFF00, 8'h00, 32'd0, 0);
    queue_access(OP_JOY_READ,  0, 0, 0, 0, 16'h1234, 8'h00, 32'd0, 0);
    wait_drained();

    // toggle on either port, only port 0 altered
    write_kind(KIND_CRICKET);
    queue_access(OP_JOY_READ, 0, 0, 1, 0, 16'hFFFF, 8'h00, 32'd0, 0);
    queue_access(OP_JOY_READ, 0, 0, 0, 0, 16'hFFFF, 8'h00, 32'd0, 0);
    wait_drained();

    write_kind(KIND_MUSIC);
    queue_access(OP_CIA_WRITE, 0, 0, 0, 0, 16'h0000, 8'h80, 32'd0, 0);
    queue_access(OP_JOY_READ,  0, 0, 1, 0, 16'hFFFF, 8'h00, 32'd0, 0);
    queue_access(OP_JOY_READ,  0, 0, 1, 0, 16'hFFFF, 8'h00, 32'd0, 0);
    wait_drained();

    // pot offset extremes
    write_kind(KIND_ITALIA);
    queue_access(OP_POT_START, 0, 0, 0, 0, 16'h0000, 8'h00, 32'd0, 0);
    queue_access(OP_ANALOG,    0, 0, 1, 0, 16'h0000, 8'h00, 32'd0, 0);
    queue_access(OP_ANALOG,    0, 0, 1, 1, 16'h0000, 8'h00, 32'd0, 0);
    queue_access(OP_POT_START, 0, 0, 0, 0, 16'h0000, 8'h00, 32'd0, 7);
    wait_drained();

    // kind changed with the flag outside 1..2
    write_kind(KIND_MUSIC);
    queue_access(OP_JOY_READ, 0, 0, 1, 0, 16'h1234, 8'h00, 32'd0, 0);
    wait_drained();

    write_kind(KIND_SPREADSHEET);
    queue_access(OP_POTGO,  0, 0, 0, 0, 16'h0000, 8'h00, 32'd0, 0);
    queue_access(OP_ANALOG, 0, 0, 0, 0, 16'h0000, 8'h00, 32'd0, 0);
    queue_access(OP_ANALOG, 0, 0, 1, 1, 16'h0000, 8'h00, 32'd0, 0);
    wait_drained();

    write_kind(KIND_DRAUGHTS);
    queue_access(OP_ANALOG, 0, 0, 1, 0, 16'h0000, 8'h00, 32'd0, 0);
    wait_drained();

    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      set_idling(blk % 4);
      write_kind((blk < 11) ? KIND_W'(blk) : KIND_W'($urandom_range(10)));
      if (blk == 0) start_hold = 1'b1;
      for (n = 0; n < BLOCK_ITEMS; n++) queue_item(random_access());
      wait_drained();
    end
    write_kind(KIND_SPREADSHEET);

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
